@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_BLOCK  = 3'd1,
    ST_BAD_ARG   = 3'd2,
    ST_NOT_FREE  = 3'd3,
    ST_PARTIAL   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_SCAN,
    S_SCAN_CHK,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_FREE_CLR,
    S_RES_RD,
    S_RES_CHK,
    S_RES_SPLIT,
    S_DONE
  } fsm_e;

endpackage

@@ hw/rtl/bpa_map_ram.sv @@
module bpa_map_ram #(
  parameter int unsigned Depth = 2048,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/buddy_page_allocator_unit.sv @@
// Channel   | Direction | Contents
// s_axis    | in        | tdata: operation[1:0], order[4:2], page[14:5]
// m_axis    | out       | tdata: status[2:0], start_page[12:3]
// cfg       | in        | page_count[10:0]
// Each order k occupies a region of PAGES>>k bits in one single-port-read map RAM.
// Rejected requests go straight to the result. Allocate reads one map bit at a time, order
// by order upward from the requested one, then splits one level per cycle; free checks the
// buddy and merges while it is free, one level at a time; reserve probes orders from the top
// down, then splits to order 0; init clears every map bit then seeds one top block per cycle.
// After reset the map is cleared by a sweep over every map bit; no request is taken then.
// The result register holds while m_axis_tready is low; one request is in flight at a time.
module buddy_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int unsigned TOP_ORDER = 6,
  parameter int unsigned PAGES     = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // operation, order, page
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status, start_page
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int unsigned Depth = 2 * PAGES;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned KW = $clog2(TOP_ORDER + 2);
  localparam int unsigned IW = AW;

  fsm_e state_q, state_d;
  logic [10:0] pc_q;
  logic [1:0] op_q, op_d;
  logic [2:0] ord_q, ord_d;
  logic [9:0] page_q, page_d;
  logic [KW-1:0] k_q, k_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [2:0] st_q, st_d;
  logic [9:0] sp_q, sp_d;

  logic we, wd, rdata;
  logic [AW-1:0] wa, ra;

  bpa_map_ram #(.Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] base_of(input logic [KW-1:0] k);
    logic [AW:0] b;
    b = '0;
    for (int j = 0; j <= TOP_ORDER; j++) begin
      if (j < k) b = b + (AW+1)'(PAGES >> j);
    end
    return b[AW-1:0];
  endfunction

  function automatic logic [IW-1:0] nblk(input logic [KW-1:0] k);
    return IW'(PAGES >> k);
  endfunction

  logic [AW-1:0] seed_n;
  logic seed_part;
  always_comb begin
    logic [10:0] n;
    n = (pc_q > 11'(PAGES)) ? 11'(PAGES) : pc_q;
    seed_part = (pc_q > 11'(PAGES)) || ((n & 11'((1 << TOP_ORDER) - 1)) != 0);
    seed_n = AW'(n >> TOP_ORDER);
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pc_q <= 11'd1024;
    else if (cfg_valid) pc_q <= cfg_data;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_DONE);
  assign m_axis_tdata  = {3'b0, sp_q, st_q};

  logic [IW-1:0] bud;
  logic [IW:0] pidx;
  assign bud = idx_q ^ IW'(1);

  always_comb begin
    state_d = state_q; op_d = op_q; ord_d = ord_q; page_d = page_q;
    k_d = k_q; idx_d = idx_q; cnt_d = cnt_q; st_d = st_q; sp_d = sp_q;
    we = 1'b0; wa = '0; wd = 1'b0; ra = '0;
    pidx = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tdata[1:0];
          ord_d = s_axis_tdata[4:2];
          page_d = s_axis_tdata[14:5];
          st_d = ST_OK; sp_d = '0;
          case (op_e'(s_axis_tdata[1:0]))
            OP_ALLOC: begin
              if (32'(s_axis_tdata[4:2]) > TOP_ORDER) begin
                st_d = ST_NO_BLOCK; state_d = S_DONE;
              end else begin
                k_d = KW'(s_axis_tdata[4:2]); idx_d = '0; state_d = S_SCAN;
              end
            end
            OP_FREE: begin
              if (32'(s_axis_tdata[4:2]) > TOP_ORDER) begin
                st_d = ST_NO_BLOCK; state_d = S_DONE;
              end else if (((s_axis_tdata[14:5] & ((10'd1 << s_axis_tdata[4:2]) - 10'd1))
                            != 0) || (32'(s_axis_tdata[14:5]) +
                            (32'd1 << s_axis_tdata[4:2]) > PAGES)) begin
                st_d = ST_BAD_ARG; state_d = S_DONE;
              end else begin
                k_d = KW'(s_axis_tdata[4:2]);
                idx_d = IW'(s_axis_tdata[14:5] >> s_axis_tdata[4:2]);
                state_d = S_FREE_RD;
              end
            end
            OP_RESERVE: begin
              if (32'(s_axis_tdata[14:5]) >= PAGES) begin
                st_d = ST_BAD_ARG; state_d = S_DONE;
              end else begin
                k_d = KW'(TOP_ORDER); state_d = S_RES_RD;
              end
            end
            default: begin
              cnt_d = '0; state_d = S_CLEAR;
            end
          endcase
        end
      end
      S_CLEAR: begin
        we = 1'b1; wa = cnt_q; wd = 1'b0;
        cnt_d = cnt_q + AW'(1);
        if (32'(cnt_q) == Depth - 1) begin
          cnt_d = '0;
          state_d = (op_q == OP_INIT) ? S_SEED : S_IDLE;
        end
      end
      S_SEED: begin
        if (cnt_q < seed_n) begin
          we = 1'b1; wa = base_of(KW'(TOP_ORDER)) + cnt_q; wd = 1'b1;
          cnt_d = cnt_q + AW'(1);
        end else begin
          st_d = seed_part ? ST_PARTIAL : ST_OK; state_d = S_DONE;
        end
      end
      S_SCAN: begin
        ra = base_of(k_q) + AW'(idx_q);
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata) begin
          we = 1'b1; wa = base_of(k_q) + AW'(idx_q); wd = 1'b0;
          state_d = S_SPLIT;
        end else if (idx_q == nblk(k_q) - IW'(1)) begin
          if (32'(k_q) == TOP_ORDER) begin
            st_d = ST_NO_BLOCK; state_d = S_DONE;
          end else begin
            k_d = k_q + KW'(1); idx_d = '0; state_d = S_SCAN;
          end
        end else begin
          idx_d = idx_q + IW'(1); state_d = S_SCAN;
        end
      end
      S_SPLIT: begin
        if (k_q > KW'(ord_q)) begin
          we = 1'b1; wa = base_of(k_q - KW'(1)) + AW'({idx_q[IW-2:0], 1'b1}); wd = 1'b1;
          k_d = k_q - KW'(1); idx_d = {idx_q[IW-2:0], 1'b0};
        end else begin
          sp_d = 10'(idx_q << ord_q); state_d = S_DONE;
        end
      end
      S_FREE_RD: begin
        ra = base_of(k_q) + AW'(bud);
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (32'(k_q) < TOP_ORDER && bud < nblk(k_q) && rdata) begin
          we = 1'b1; wa = base_of(k_q) + AW'(bud); wd = 1'b0;
          state_d = S_FREE_CLR;
        end else begin
          we = 1'b1; wa = base_of(k_q) + AW'(idx_q); wd = 1'b1;
          state_d = S_DONE;
        end
      end
      S_FREE_CLR: begin
        we = 1'b1; wa = base_of(k_q) + AW'(idx_q); wd = 1'b0;
        idx_d = idx_q >> 1; k_d = k_q + KW'(1); state_d = S_FREE_RD;
      end
      S_RES_RD: begin
        ra = base_of(k_q) + AW'(page_q >> k_q);
        state_d = S_RES_CHK;
      end
      S_RES_CHK: begin
        if (rdata) begin
          we = 1'b1; wa = base_of(k_q) + AW'(page_q >> k_q); wd = 1'b0;
          state_d = S_RES_SPLIT;
        end else if (k_q == '0) begin
          st_d = ST_NOT_FREE; state_d = S_DONE;
        end else begin
          k_d = k_q - KW'(1); state_d = S_RES_RD;
        end
      end
      S_RES_SPLIT: begin
        if (k_q != '0) begin
          pidx = (IW+1)'(page_q >> (k_q - KW'(1))) ^ (IW+1)'(1);
          we = 1'b1; wa = base_of(k_q - KW'(1)) + AW'(pidx); wd = 1'b1;
          k_d = k_q - KW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q <= OP_ALLOC;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q <= ord_d; page_q <= page_d; k_q <= k_d; idx_q <= idx_d;
    st_q <= st_d; sp_q <= sp_d;
  end

endmodule
